FILE: hw/rtl/csc_pkg.sv
// Shared types, constants and helper functions for the climate sensor compensation block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package csc_pkg;

    typedef struct packed {
        logic [19:0] pressure;
        logic [19:0] temperature;
        logic [15:0] humidity;
    } raw_item_t;

    typedef struct packed {
        logic      valid;
        raw_item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [47:0] temp_cal;
        logic [47:0] press_cal_a;
        logic [47:0] press_cal_b;
        logic [47:0] press_cal_c;
        logic [63:0] hum_cal;
    } cal_t;

    typedef enum logic [2:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_PRESS_C = 3'd3,
        CFG_HUM     = 3'd4
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_T0, ST_T1M, ST_T2M, ST_T3M, ST_T4, ST_T5,
        ST_P0, ST_P1M, ST_P2M, ST_P3M, ST_P4, ST_P5M, ST_P6M, ST_P7, ST_P8M, ST_P9,
        ST_P10M, ST_P11D, ST_P12, ST_P13M, ST_P14M, ST_P15M, ST_P16, ST_P17,
        ST_H0, ST_H1M, ST_H2, ST_H3M, ST_H4M, ST_H5M, ST_H6M, ST_H7M, ST_H8,
        ST_H9M, ST_H10M, ST_H11, ST_DONE
    } st_t;

    localparam logic signed [63:0] TEMP_MIN  = -64'sd4000;
    localparam logic signed [63:0] TEMP_MAX  = 64'sd8500;
    localparam logic [31:0]        PRESS_MIN = 32'd7680000;
    localparam logic [31:0]        PRESS_MAX = 32'd28160000;
    localparam logic signed [63:0] HUM_CAP   = 64'sd419430400;
    localparam logic signed [63:0] P_OFFSET  = 64'sd128000;
    localparam logic signed [63:0] H_OFFSET  = 64'sd76800;
    localparam logic signed [63:0] P_BIAS    = 64'sd140737488355328;
    localparam logic signed [63:0] P_BASE    = 64'sd1048576;
    localparam logic signed [63:0] P_SCALE   = 64'sd3125;
    localparam logic [2:0]         MUL_LAST  = 3'd4;

    function automatic logic signed [63:0] w32(input logic signed [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    // Signed division by 2**k that truncates toward zero.
    function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                     input logic [5:0] k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/csc_queue.sv
// Front part: accepts raw sample transactions into a short queue.
// Depends on csc_pkg.
`default_nettype none
module csc_queue
    import csc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire raw_item_t   push_item,
    output logic             full,
    input  wire logic        pop,
    output queue_head_t      head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    raw_item_t      store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csc_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on csc_pkg.
`default_nettype none
module csc_div
    import csc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] dividend,
    input  wire logic signed [63:0] divisor,
    output logic                    done,
    output logic signed [63:0]      quotient
);

    logic        run_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic [64:0] trial;

    assign trial    = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == 6'd63);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            den_reg <= divisor[63] ? 64'(-divisor) : 64'(divisor);
            neg_reg <= dividend[63] ^ divisor[63];
        end
        else if (run_reg)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/csc_back.sv
// Back part: sequencer with a shared 64x16 multiplier that runs the compensation formulas.
// Depends on csc_pkg and csc_div.
`default_nettype none
module csc_back
    import csc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire queue_head_t  head,
    output logic              pop,
    input  wire cal_t         cal,
    output logic              result_valid,
    output logic signed [14:0] temperature_centi,
    output logic [24:0]       pressure_q24_8,
    output logic [16:0]       humidity_q22_10,
    output logic signed [31:0] fine_temperature
);

    st_t state_reg, state_next;

    raw_item_t          raw_reg;
    logic [2:0]         mcnt_reg, mcnt_next;
    logic [63:0]        acc_reg, acc_next;
    logic signed [63:0] ra, rb, rc, r4, r5, r7, r8, r9, q1, qq;
    logic signed [31:0] fine_reg;
    logic signed [14:0] temp_reg;
    logic [24:0]        press_reg;
    logic [16:0]        hum_reg;
    logic               valid_reg;
    logic signed [14:0] temp_out_reg;
    logic [24:0]        press_out_reg;
    logic [16:0]        hum_out_reg;
    logic signed [31:0] fine_out_reg;

    logic               mul_state;
    logic               mul_wb;
    logic               div_start;
    logic               div_done;
    logic signed [63:0] div_q;
    logic signed [63:0] mul_a, mul_b;
    logic [15:0]        chunk;
    logic [79:0]        part_full;
    logic [63:0]        part;
    logic signed [63:0] acc_s;

    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] h1, h2, h3, h4, h5, h6, fine64;
    logic signed [63:0] t5_sum, t5_val, p17_val, e12;
    logic [31:0]        p17_u;

    assign t1 = {48'd0, cal.temp_cal[15:0]};
    assign t2 = {{48{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
    assign t3 = {{48{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
    assign p1 = {48'd0, cal.press_cal_a[15:0]};
    assign p2 = {{48{cal.press_cal_a[31]}}, cal.press_cal_a[31:16]};
    assign p3 = {{48{cal.press_cal_a[47]}}, cal.press_cal_a[47:32]};
    assign p4 = {{48{cal.press_cal_b[15]}}, cal.press_cal_b[15:0]};
    assign p5 = {{48{cal.press_cal_b[31]}}, cal.press_cal_b[31:16]};
    assign p6 = {{48{cal.press_cal_b[47]}}, cal.press_cal_b[47:32]};
    assign p7 = {{48{cal.press_cal_c[15]}}, cal.press_cal_c[15:0]};
    assign p8 = {{48{cal.press_cal_c[31]}}, cal.press_cal_c[31:16]};
    assign p9 = {{48{cal.press_cal_c[47]}}, cal.press_cal_c[47:32]};
    assign h1 = {56'd0, cal.hum_cal[7:0]};
    assign h2 = {{48{cal.hum_cal[23]}}, cal.hum_cal[23:8]};
    assign h3 = {56'd0, cal.hum_cal[31:24]};
    assign h4 = {{52{cal.hum_cal[43]}}, cal.hum_cal[43:32]};
    assign h5 = {{52{cal.hum_cal[55]}}, cal.hum_cal[55:44]};
    assign h6 = {{56{cal.hum_cal[63]}}, cal.hum_cal[63:56]};
    assign fine64 = {{32{fine_reg[31]}}, fine_reg};

    assign mul_state = state_reg inside {ST_T1M, ST_T2M, ST_T3M, ST_P1M, ST_P2M, ST_P3M,
                                         ST_P5M, ST_P6M, ST_P8M, ST_P10M, ST_P13M, ST_P14M,
                                         ST_P15M, ST_H1M, ST_H3M, ST_H4M, ST_H5M, ST_H6M,
                                         ST_H7M, ST_H9M, ST_H10M};
    assign mul_wb = mul_state && (mcnt_reg == MUL_LAST);
    assign acc_s  = $signed(acc_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T1M:  begin mul_a = ra; mul_b = t2; end
            ST_T2M:  begin mul_a = rc; mul_b = rc; end
            ST_T3M:  begin mul_a = rc; mul_b = t3; end
            ST_P1M:  begin mul_a = q1; mul_b = q1; end
            ST_P2M:  begin mul_a = qq; mul_b = p6; end
            ST_P3M:  begin mul_a = q1; mul_b = p5; end
            ST_P5M:  begin mul_a = qq; mul_b = p3; end
            ST_P6M:  begin mul_a = q1; mul_b = p2; end
            ST_P8M:  begin mul_a = r5; mul_b = p1; end
            ST_P10M: begin mul_a = r8; mul_b = P_SCALE; end
            ST_P13M: begin mul_a = p9; mul_b = ra; end
            ST_P14M: begin mul_a = rb; mul_b = ra; end
            ST_P15M: begin mul_a = p8; mul_b = r9; end
            ST_H1M:  begin mul_a = h5; mul_b = q1; end
            ST_H3M:  begin mul_a = q1; mul_b = h6; end
            ST_H4M:  begin mul_a = q1; mul_b = h3; end
            ST_H5M:  begin mul_a = ra; mul_b = w32(rb + 64'sd32768); end
            ST_H6M:  begin mul_a = rc; mul_b = h2; end
            ST_H7M:  begin mul_a = r5; mul_b = rb; end
            ST_H9M:  begin mul_a = ra; mul_b = ra; end
            ST_H10M: begin mul_a = rc; mul_b = h1; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign chunk     = mul_b[{mcnt_reg[1:0], 4'd0} +: 16];
    assign part_full = {16'd0, mul_a} * {64'd0, chunk};
    assign part      = part_full[63:0] << {mcnt_reg[1:0], 4'd0};

    always_comb
    begin
        mcnt_next = '0;
        acc_next  = acc_reg;
        if (mul_state && (mcnt_reg != MUL_LAST))
        begin
            mcnt_next = mcnt_reg + 1'b1;
            acc_next  = ((mcnt_reg == 3'd0) ? 64'd0 : acc_reg) + part;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_T0;
                end
            end
            ST_P9:
            begin
                state_next = (r7 == '0) ? ST_H0 : ST_P10M;
            end
            ST_P11D:
            begin
                if (div_done)
                begin
                    state_next = ST_P12;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                if (!mul_state || mul_wb)
                begin
                    state_next = st_t'(state_reg + 6'd1);
                end
            end
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && head.valid;
        div_start = (state_reg == ST_P10M) && mul_wb;
    end

    csc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_s),
        .divisor  (r7),
        .done     (div_done),
        .quotient (div_q)
    );

    assign t5_sum  = w32((fine64 <<< 2) + fine64 + 64'sd128);
    assign t5_val  = sdiv_pow2(t5_sum, 6'd8);
    assign p17_val = sdiv_pow2(r9, 6'd8) + (p7 <<< 4);
    assign p17_u   = p17_val[31:0];
    assign e12     = (r8 < 0) ? 64'sd0 : ((r8 > HUM_CAP) ? HUM_CAP : r8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            valid_reg <= (state_reg == ST_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        case (state_reg)
            ST_IDLE: if (head.valid) raw_reg <= head.item;
            ST_T0:
            begin
                ra <= w32({47'd0, raw_reg.temperature[19:3]} - (t1 <<< 1));
                rc <= w32({48'd0, raw_reg.temperature[19:4]} - t1);
            end
            ST_T1M: if (mul_wb) rb <= sdiv_pow2(w32(acc_s), 6'd11);
            ST_T2M: if (mul_wb) rc <= sdiv_pow2(w32(acc_s), 6'd12);
            ST_T3M: if (mul_wb) rc <= sdiv_pow2(w32(acc_s), 6'd14);
            ST_T4:  fine_reg <= 32'(rb + rc);
            ST_T5:
            begin
                if (t5_val < TEMP_MIN)      temp_reg <= 15'(TEMP_MIN);
                else if (t5_val > TEMP_MAX) temp_reg <= 15'(TEMP_MAX);
                else                        temp_reg <= t5_val[14:0];
            end
            ST_P0:  q1 <= fine64 - P_OFFSET;
            ST_P1M: if (mul_wb) qq <= acc_s;
            ST_P2M: if (mul_wb) r4 <= acc_s;
            ST_P3M: if (mul_wb) r4 <= r4 + (acc_s <<< 17);
            ST_P4:  r4 <= r4 + (p4 <<< 35);
            ST_P5M: if (mul_wb) r5 <= sdiv_pow2(acc_s, 6'd8);
            ST_P6M: if (mul_wb) r5 <= r5 + (acc_s <<< 12);
            ST_P7:  r5 <= r5 + P_BIAS;
            ST_P8M: if (mul_wb) r7 <= sdiv_pow2(acc_s, 6'd33);
            ST_P9:
            begin
                r8 <= ((P_BASE - {44'd0, raw_reg.pressure}) <<< 31) - r4;
                if (r7 == '0) press_reg <= PRESS_MIN[24:0];
            end
            ST_P11D: if (div_done) r9 <= div_q;
            ST_P12:  ra <= sdiv_pow2(r9, 6'd13);
            ST_P13M: if (mul_wb) rb <= acc_s;
            ST_P14M: if (mul_wb) rb <= sdiv_pow2(acc_s, 6'd25);
            ST_P15M: if (mul_wb) rc <= sdiv_pow2(acc_s, 6'd19);
            ST_P16:  r9 <= r9 + rb + rc;
            ST_P17:
            begin
                if (p17_u < PRESS_MIN)      press_reg <= PRESS_MIN[24:0];
                else if (p17_u > PRESS_MAX) press_reg <= PRESS_MAX[24:0];
                else                        press_reg <= p17_u[24:0];
            end
            ST_H0:
            begin
                q1 <= w32(fine64 - H_OFFSET);
                r4 <= w32(h4 <<< 20);
            end
            ST_H1M: if (mul_wb) rb <= w32(acc_s);
            ST_H2:
                r5 <= sdiv_pow2(w32({34'd0, raw_reg.humidity, 14'd0} - r4 - rb + 64'sd16384),
                                6'd15);
            ST_H3M: if (mul_wb) ra <= sdiv_pow2(w32(acc_s), 6'd10);
            ST_H4M: if (mul_wb) rb <= sdiv_pow2(w32(acc_s), 6'd11);
            ST_H5M: if (mul_wb) rc <= w32(sdiv_pow2(w32(acc_s), 6'd10) + 64'sd2097152);
            ST_H6M: if (mul_wb) rb <= sdiv_pow2(w32(acc_s + 64'sd8192), 6'd14);
            ST_H7M: if (mul_wb) r9 <= w32(acc_s);
            ST_H8:  ra <= sdiv_pow2(r9, 6'd15);
            ST_H9M: if (mul_wb) rc <= sdiv_pow2(w32(acc_s), 6'd7);
            ST_H10M: if (mul_wb) r8 <= w32(r9 - sdiv_pow2(w32(acc_s), 6'd4));
            ST_H11: hum_reg <= e12[28:12];
            ST_DONE:
            begin
                temp_out_reg  <= temp_reg;
                press_out_reg <= press_reg;
                hum_out_reg   <= hum_reg;
                fine_out_reg  <= fine_reg;
            end
            default: ;
        endcase
    end

    assign result_valid      = valid_reg;
    assign temperature_centi = temp_out_reg;
    assign pressure_q24_8    = press_out_reg;
    assign humidity_q22_10   = hum_out_reg;
    assign fine_temperature  = fine_out_reg;

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

    a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pressure_q24_8 >= PRESS_MIN[24:0]) &&
                         (pressure_q24_8 <= PRESS_MAX[24:0]))
        else $error("pressure out of range");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (r7 != '0))
        else $error("divider started with zero divisor");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_T0))
        else $error("queue popped without starting a transaction");

endmodule
`default_nettype wire

FILE: hw/rtl/climate_sensor_compensation.sv
// Top level: calibration registers, front queue and back compensation sequencer.
// Depends on csc_pkg, csc_queue, csc_back.
//
// Channel    Direction  Handshake             Payload
// sample     in         start & !busy         raw_pressure, raw_temperature, raw_humidity
// result     out        result_valid strobe   temperature_centi, pressure_q24_8,
//                                             humidity_q22_10, fine_temperature
// config     in         cfg_write             cfg_index, cfg_data
//
// Each transaction holds the back part through 21 multiplications on the shared 64x16
// multiplier and a wait on the 64-step divider; when the pressure divisor is zero it
// needs only 17 multiplications and skips the divider.
// Reset clears the queue, the sequencer and all calibration registers.
// Results cannot be stalled; busy is high only while the queue is full.
`default_nettype none
module climate_sensor_compensation
    import csc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [19:0]  raw_pressure,
    input  wire logic [19:0]  raw_temperature,
    input  wire logic [15:0]  raw_humidity,
    output logic              result_valid,
    output logic signed [14:0] temperature_centi,
    output logic [24:0]       pressure_q24_8,
    output logic [16:0]       humidity_q22_10,
    output logic signed [31:0] fine_temperature,
    input  wire logic         cfg_write,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    cal_t        cal_reg;
    raw_item_t   in_item;
    queue_head_t head;
    logic        full;
    logic        pop;

    assign in_item.pressure    = raw_pressure;
    assign in_item.temperature = raw_temperature;
    assign in_item.humidity    = raw_humidity;
    assign busy                = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TEMP:    cal_reg.temp_cal    <= cfg_data[47:0];
                CFG_PRESS_A: cal_reg.press_cal_a <= cfg_data[47:0];
                CFG_PRESS_B: cal_reg.press_cal_b <= cfg_data[47:0];
                CFG_PRESS_C: cal_reg.press_cal_c <= cfg_data[47:0];
                CFG_HUM:     cal_reg.hum_cal     <= cfg_data;
                default:     ;
            endcase
        end
    end

    csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_item (in_item),
        .full      (full),
        .pop       (pop),
        .head      (head)
    );

    csc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .pop               (pop),
        .cal               (cal_reg),
        .result_valid      (result_valid),
        .temperature_centi (temperature_centi),
        .pressure_q24_8    (pressure_q24_8),
        .humidity_q22_10   (humidity_q22_10),
        .fine_temperature  (fine_temperature)
    );

endmodule
`default_nettype wire
